/* rtl/pocx_pkg.sv */
// Package for the permutation order crossover unit: item structs, function codes,
// sequencer step and control word types, and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pocx_pkg;

  localparam int GeneW    = 6;   // gene identifier width
  localparam int NumGenes = 64;  // distinct gene identifiers (mark vector size)
  localparam int CountW   = 7;   // gene_count register width
  localparam int CutHiW   = 7;

  typedef enum logic [1:0] {
    FUNC_LOAD_FIRST  = 2'd0,
    FUNC_LOAD_SECOND = 2'd1,
    FUNC_COMPUTE     = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [GeneW-1:0]  gene;
    logic [GeneW-1:0]  cut_low;
    logic [CutHiW-1:0] cut_high;
  } in_item_t;

  typedef struct packed {
    logic [GeneW-1:0] position;
    logic [GeneW-1:0] child_one_gene;
    logic [GeneW-1:0] child_two_gene;
    logic             last_gene;
  } out_item_t;

  // Sequencer steps (ROM addresses).
  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_SETUP     = 4'd1,
    ST_MRK_RD    = 4'd2,
    ST_MRK_SET   = 4'd3,
    ST_SCAN_INIT = 4'd4,
    ST_SCAN_RD   = 4'd5,
    ST_FILL      = 4'd6,
    ST_OUT_INIT  = 4'd7,
    ST_OUT_RD    = 4'd8,
    ST_EMIT      = 4'd9,
    ST_DONE      = 4'd10
  } step_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDLE,
    OP_SETUP,
    OP_MARK,
    OP_SCAN_INIT,
    OP_FILL,
    OP_OUT_INIT,
    OP_EMIT,
    OP_DONE
  } op_e;

  // Jump conditions: when true go to target, else fall through to the next step.
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_NO_START,
    C_EMPTY,
    C_MORE_SEG,
    C_MORE_GENES
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  hold_out;  // wait here while the output register is full and stalled
    step_e target;
  } ctrl_t;

  function automatic ctrl_t ucode_word(step_e s);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_GOTO, hold_out: 1'b0, target: ST_IDLE};
    unique case (s)
      ST_IDLE:      w = '{op: OP_IDLE,      cond: C_NO_START,   hold_out: 1'b0,
                          target: ST_IDLE};
      ST_SETUP:     w = '{op: OP_SETUP,     cond: C_EMPTY,      hold_out: 1'b0,
                          target: ST_SCAN_INIT};
      ST_MRK_RD:    w = '{op: OP_NONE,      cond: C_NEXT,       hold_out: 1'b0,
                          target: ST_IDLE};
      ST_MRK_SET:   w = '{op: OP_MARK,      cond: C_MORE_SEG,   hold_out: 1'b0,
                          target: ST_MRK_RD};
      ST_SCAN_INIT: w = '{op: OP_SCAN_INIT, cond: C_NEXT,       hold_out: 1'b0,
                          target: ST_IDLE};
      ST_SCAN_RD:   w = '{op: OP_NONE,      cond: C_NEXT,       hold_out: 1'b0,
                          target: ST_IDLE};
      ST_FILL:      w = '{op: OP_FILL,      cond: C_MORE_GENES, hold_out: 1'b0,
                          target: ST_SCAN_RD};
      ST_OUT_INIT:  w = '{op: OP_OUT_INIT,  cond: C_NEXT,       hold_out: 1'b0,
                          target: ST_IDLE};
      ST_OUT_RD:    w = '{op: OP_NONE,      cond: C_NEXT,       hold_out: 1'b0,
                          target: ST_IDLE};
      ST_EMIT:      w = '{op: OP_EMIT,      cond: C_MORE_GENES, hold_out: 1'b1,
                          target: ST_OUT_RD};
      ST_DONE:      w = '{op: OP_DONE,      cond: C_GOTO,       hold_out: 1'b0,
                          target: ST_IDLE};
      default:      w = '{op: OP_NONE,      cond: C_GOTO,       hold_out: 1'b0,
                          target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/permutation_order_crossover_unit.sv */
// Order crossover (OX) unit: parent memories, child memories, segment marks and a
// microcoded sequencer that builds and streams both children.
// Depends on pocx_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_item_i  (func, gene, cuts)
//  out     | output    | out_valid_o / out_stall_i| out_item_o (position, genes, last)
//  cfg     | input     | cfg_we_i                 | cfg_wdata_i (gene_count)
//
// A load item is written in the idle step. A compute item marks the hi - lo segment
// positions, then scans and emits all n positions (n = effective gene count, hi/lo =
// ordered, saturated cuts): each position costs one address step and one use step,
// because each parent memory has a single registered read port.
// The input is stalled for the whole compute item; output stalls hold the EMIT step.
// Reset clears the sequencer, load counts, marks and output valid; gene_count resets to 64.
// Parent and child memories are not cleared; only written child entries are used.
`timescale 1ns / 1ps
`default_nettype none

module permutation_order_crossover_unit
  import pocx_pkg::*;
#(
  parameter int MAX_GENES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_item_o
);

  localparam int AW = $clog2(MAX_GENES);  // memory address width
  localparam int CW = AW + 1;             // counts and positions up to MAX_GENES

  // ---------------------------------------------------------------- registers
  logic [CountW-1:0] gene_count_q;
  step_e             step_q, step_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]     next1_q, next1_d, next2_q, next2_d;  // next fill slot per child
  logic [CW-1:0]     fcnt_q, fcnt_d, scnt_q, scnt_d;      // parent load counts
  logic [NumGenes-1:0] m1_q, m1_d, m2_q, m2_d;            // segment marks
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  // memories
  logic [GeneW-1:0] fp_mem [MAX_GENES];
  logic [GeneW-1:0] sp_mem [MAX_GENES];
  logic [GeneW-1:0] c1_mem [MAX_GENES];
  logic [GeneW-1:0] c2_mem [MAX_GENES];
  logic [GeneW-1:0] fp_rd_q, sp_rd_q, c1_rd_q, c2_rd_q;

  logic          fp_we, sp_we, c1_we, c2_we;
  logic [AW-1:0] fp_waddr, sp_waddr, rd_addr;

  // ---------------------------------------------------------------- helpers
  ctrl_t         cw;
  logic          in_accept, start, out_free, op_en, take;
  logic [CW-1:0] n_c, addr_inc, f_idx, s_idx, cut_lo_c, cut_hi_c;
  logic          in_seg1, in_seg2;

  assign cw        = ucode_word(step_q);
  assign in_stall_o = (step_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign start     = in_accept && (func_e'(in_item_i.func) == FUNC_COMPUTE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign op_en     = !(cw.hold_out && !out_free);
  assign addr_inc  = addr_q + CW'(1);
  assign rd_addr   = addr_q[AW-1:0];

  // effective gene count, clamped to 2..MAX_GENES
  always_comb begin
    if (gene_count_q < CountW'(2)) begin
      n_c = CW'(2);
    end else if (32'(gene_count_q) > 32'(MAX_GENES)) begin
      n_c = CW'(MAX_GENES);
    end else begin
      n_c = CW'(gene_count_q);
    end
  end

  // ordered, saturated cut points
  always_comb begin
    logic [31:0] a, b, t, nn;
    a  = 32'(in_item_i.cut_low);
    b  = 32'(in_item_i.cut_high);
    nn = 32'(n_c);
    t  = '0;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (a > nn) a = nn;
    if (b > nn) b = nn;
    cut_lo_c = CW'(a);
    cut_hi_c = CW'(b);
  end

  // load slot: wraps to 0 once the count reaches n
  assign f_idx = (fcnt_q >= n_c) ? '0 : fcnt_q;
  assign s_idx = (scnt_q >= n_c) ? '0 : scnt_q;

  assign in_seg1 = (addr_q >= lo_q) && (addr_q < next1_q);
  assign in_seg2 = (addr_q >= lo_q) && (addr_q < next2_q);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    unique case (cw.cond)
      C_NEXT:       take = 1'b0;
      C_GOTO:       take = 1'b1;
      C_NO_START:   take = !start;
      C_EMPTY:      take = (lo_q == hi_q);
      C_MORE_SEG:   take = (addr_inc < hi_q);
      C_MORE_GENES: take = (addr_inc < n_c);
      default:      take = 1'b0;
    endcase

    if (!op_en) begin
      step_d = step_q;
    end else if (take) begin
      step_d = cw.target;
    end else begin
      step_d = step_e'(step_q + 4'd1);
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    addr_d      = addr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    next1_d     = next1_q;
    next2_d     = next2_q;
    fcnt_d      = fcnt_q;
    scnt_d      = scnt_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    fp_we       = 1'b0;
    sp_we       = 1'b0;
    fp_waddr    = f_idx[AW-1:0];
    sp_waddr    = s_idx[AW-1:0];
    c1_we       = 1'b0;
    c2_we       = 1'b0;

    if (op_en) begin
      unique case (cw.op)
        OP_IDLE: begin
          if (in_accept) begin
            unique case (func_e'(in_item_i.func))
              FUNC_LOAD_FIRST: begin
                fp_we  = 1'b1;
                fcnt_d = f_idx + CW'(1);
              end
              FUNC_LOAD_SECOND: begin
                sp_we  = 1'b1;
                scnt_d = s_idx + CW'(1);
              end
              FUNC_COMPUTE: begin
                lo_d = cut_lo_c;
                hi_d = cut_hi_c;
              end
              default: ;
            endcase
          end
        end
        OP_SETUP: begin
          addr_d  = lo_q;
          next1_d = lo_q;
          next2_d = lo_q;
          m1_d    = '0;
          m2_d    = '0;
        end
        OP_MARK: begin
          m1_d[fp_rd_q] = 1'b1;
          m2_d[sp_rd_q] = 1'b1;
          addr_d        = addr_inc;
        end
        OP_SCAN_INIT, OP_OUT_INIT: begin
          addr_d = '0;
        end
        OP_FILL: begin
          // child one takes first-parent segment genes in second-parent order
          if (m1_q[sp_rd_q] && (next1_q < hi_q)) begin
            c1_we   = 1'b1;
            next1_d = next1_q + CW'(1);
          end
          if (m2_q[fp_rd_q] && (next2_q < hi_q)) begin
            c2_we   = 1'b1;
            next2_d = next2_q + CW'(1);
          end
          addr_d = addr_inc;
        end
        OP_EMIT: begin
          out_valid_d               = 1'b1;
          out_item_d.position       = GeneW'(addr_q);
          out_item_d.child_one_gene = in_seg1 ? c1_rd_q : fp_rd_q;
          out_item_d.child_two_gene = in_seg2 ? c2_rd_q : sp_rd_q;
          out_item_d.last_gene      = (addr_inc == n_c);
          addr_d                    = addr_inc;
        end
        OP_DONE: begin
          fcnt_d = '0;
          scnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gene_count_q <= CountW'(64);
      step_q       <= ST_IDLE;
      fcnt_q       <= '0;
      scnt_q       <= '0;
      m1_q         <= '0;
      m2_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) gene_count_q <= cfg_wdata_i;
      step_q      <= step_d;
      fcnt_q      <= fcnt_d;
      scnt_q      <= scnt_d;
      m1_q        <= m1_d;
      m2_q        <= m2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    next1_q    <= next1_d;
    next2_q    <= next2_d;
    out_item_q <= out_item_d;
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (fp_we) fp_mem[fp_waddr] <= in_item_i.gene;
    fp_rd_q <= fp_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sp_we) sp_mem[sp_waddr] <= in_item_i.gene;
    sp_rd_q <= sp_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (c1_we) c1_mem[next1_q[AW-1:0]] <= sp_rd_q;
    c1_rd_q <= c1_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (c2_we) c2_mem[next2_q[AW-1:0]] <= fp_rd_q;
    c2_rd_q <= c2_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // a new result is only loaded by the EMIT step
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == ST_EMIT)
    else $error("output loaded outside EMIT");

  // cut points stay ordered and within the gene count during a compute item
  a_cuts_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_IDLE) |-> (lo_q <= hi_q) && (hi_q <= n_c))
    else $error("cut points out of order or range");

  // fill pointers never pass the segment end
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_IDLE && step_q != ST_SETUP) |->
      (next1_q <= hi_q) && (next2_q <= hi_q) && (next1_q >= lo_q) && (next2_q >= lo_q))
    else $error("fill pointer outside segment");

  // the last position ends the program
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_EMIT && op_en && out_item_d.last_gene) |=> step_q == ST_DONE)
    else $error("last position did not finish the item");
`endif

endmodule

`default_nettype wire

/* verif/tb_permutation_order_crossover_unit.sv */
// Self-checking testbench for permutation_order_crossover_unit: loads parent permutations,
// runs order crossover compute items and checks every streamed child position.
// Depends on pocx_pkg and the unit's RTL; no files, no arguments.
`timescale 1ns / 1ps
`default_nettype none

module tb_permutation_order_crossover_unit;
  import pocx_pkg::*;

  localparam int MAX_GENES   = 64;
  localparam int CYCLE_LIMIT = 600000;  // far above the slowest stalled run
  localparam int SETTLE      = 20;      // cycles allowed after the last child item

  // func 3 has no member in func_e; the unit must drop it
  localparam logic [1:0] FuncUnused = 2'd3;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;

  always #6 clk = ~clk;

  permutation_order_crossover_unit #(
    .MAX_GENES(MAX_GENES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  in_item_t  pending_items[$];      // items waiting for the driver
  out_item_t expected_children[$];  // predicted child items, oldest first
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        send_gap_pct   = 0;    // chance the driver leaves a slot empty
  int        recv_stall_pct = 0;    // chance the monitor stalls the output

  // Predictor copy of the unit's architectural state
  logic [CountW-1:0] model_gene_count;
  logic [GeneW-1:0]  parent_a [MAX_GENES];
  logic [GeneW-1:0]  parent_b [MAX_GENES];
  int unsigned       load_a_count;
  int unsigned       load_b_count;

  // Stimulus-side bookkeeping: which parent slots hold data, so a compute never
  // reads a slot that was never loaded
  int unsigned       plan_n;
  int unsigned       plan_fill_a;
  int unsigned       plan_fill_b;
  logic [63:0]       plan_written_a;
  logic [63:0]       plan_written_b;
  int                planned;       // items queued that the unit acts on

  // gene_count is clamped into 2..MAX_GENES inside the unit
  function automatic int unsigned clamp_count(input logic [CountW-1:0] raw);
    int unsigned n;
    n = 32'(raw);
    if (n < 2) n = 2;
    if (n > MAX_GENES) n = MAX_GENES;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Crossover predictor: updates the parent copies on loads and produces the
  // n child items of a compute item.
  // ---------------------------------------------------------------------------
  function automatic void crossover_predict(input in_item_t it);
    logic [1:0]       marks [NumGenes];
    logic [GeneW-1:0] kid_a [MAX_GENES];
    logic [GeneW-1:0] kid_b [MAX_GENES];
    int unsigned      n, lo, hi, swap_tmp, slot_a, slot_b, i, idx;
    out_item_t        res;
    n = clamp_count(model_gene_count);
    case (it.func)
      FUNC_LOAD_FIRST: begin
        // a full parent wraps back to slot 0
        idx = load_a_count;
        if (idx >= n) idx = 0;
        parent_a[idx] = it.gene;
        load_a_count = idx + 1;
      end
      FUNC_LOAD_SECOND: begin
        idx = load_b_count;
        if (idx >= n) idx = 0;
        parent_b[idx] = it.gene;
        load_b_count = idx + 1;
      end
      FUNC_COMPUTE: begin
        lo = 32'(it.cut_low);
        hi = 32'(it.cut_high);
        if (lo > hi) begin
          swap_tmp = lo;
          lo = hi;
          hi = swap_tmp;
        end
        if (lo > n) lo = n;
        if (hi > n) hi = n;
        // bit 0: gene sits in parent A's segment, bit 1: in parent B's
        for (i = 0; i < NumGenes; i++) marks[i] = 2'b00;
        for (i = lo; i < hi; i++) begin
          marks[parent_a[i]][0] = 1'b1;
          marks[parent_b[i]][1] = 1'b1;
        end
        for (i = 0; i < n; i++) begin
          kid_a[i] = parent_a[i];
          kid_b[i] = parent_b[i];
        end
        // segment slots take marked genes in the other parent's order;
        // slots left over keep the own parent's gene
        slot_a = lo;
        slot_b = lo;
        for (i = 0; i < n; i++) begin
          if (slot_a < hi && marks[parent_b[i]][0]) begin
            kid_a[slot_a] = parent_b[i];
            slot_a++;
          end
          if (slot_b < hi && marks[parent_a[i]][1]) begin
            kid_b[slot_b] = parent_a[i];
            slot_b++;
          end
        end
        for (i = 0; i < n; i++) begin
          res.position       = GeneW'(i);
          res.child_one_gene = kid_a[i];
          res.child_two_gene = kid_b[i];
          res.last_gene      = (i + 1 == n);
          expected_children.insert(expected_children.size(), res);
        end
        load_a_count = 0;
        load_b_count = 0;
      end
      default: ;  // unused func: dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void plan_load(input bit to_second, input logic [GeneW-1:0] g);
    in_item_t    it;
    int unsigned idx;
    it.func     = to_second ? FUNC_LOAD_SECOND : FUNC_LOAD_FIRST;
    it.gene     = g;
    it.cut_low  = GeneW'($urandom());   // don't-care on loads
    it.cut_high = CutHiW'($urandom());
    idx = to_second ? plan_fill_b : plan_fill_a;
    if (idx >= plan_n) idx = 0;
    if (to_second) begin
      plan_written_b[idx] = 1'b1;
      plan_fill_b = idx + 1;
    end else begin
      plan_written_a[idx] = 1'b1;
      plan_fill_a = idx + 1;
    end
    pending_items.insert(pending_items.size(), it);
    planned++;
  endfunction

  function automatic void plan_compute(input logic [GeneW-1:0] lo,
                                       input logic [CutHiW-1:0] hi);
    in_item_t it;
    it.func     = FUNC_COMPUTE;
    it.gene     = GeneW'($urandom());
    it.cut_low  = lo;
    it.cut_high = hi;
    plan_fill_a = 0;
    plan_fill_b = 0;
    pending_items.insert(pending_items.size(), it);
    planned++;
  endfunction

  function automatic void plan_unused();
    in_item_t it;
    it          = in_item_t'($urandom());
    it.func     = FuncUnused;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // Mostly cuts inside 0..n in either order, some empty segments, some raw field values
  function automatic void plan_random_compute();
    int unsigned r, top_lo, v;
    r = $urandom_range(0, 99);
    top_lo = (plan_n > 63) ? 63 : plan_n;
    if (r < 60) begin
      plan_compute(GeneW'($urandom_range(0, top_lo)), CutHiW'($urandom_range(0, plan_n)));
    end else if (r < 75) begin
      v = $urandom_range(0, top_lo);
      plan_compute(GeneW'(v), CutHiW'(v));
    end else begin
      plan_compute(GeneW'($urandom()), CutHiW'($urandom()));
    end
  endfunction

  function automatic void shuffle_genes(inout logic [GeneW-1:0] g [NumGenes],
                                        input int unsigned len);
    int unsigned      j, k;
    logic [GeneW-1:0] tmp;
    for (j = len - 1; j > 0; j--) begin
      k    = $urandom_range(0, j);
      tmp  = g[j];
      g[j] = g[k];
      g[k] = tmp;
    end
  endfunction

  // Two parents (usually permutations of one gene set), loads interleaved at
  // random, then one to three compute items on them.
  function automatic void plan_crossover_set();
    logic [GeneW-1:0] pool  [NumGenes];
    logic [GeneW-1:0] other [NumGenes];
    int unsigned      a, b, i;
    for (i = 0; i < NumGenes; i++) pool[i] = GeneW'(i);
    shuffle_genes(pool, NumGenes);
    if ($urandom_range(0, 9) == 0)  // repeated gene in parent A
      pool[$urandom_range(0, plan_n - 1)] = pool[$urandom_range(0, plan_n - 1)];
    other = pool;
    shuffle_genes(other, plan_n);
    if ($urandom_range(0, 9) == 0)  // stray gene in parent B
      other[$urandom_range(0, plan_n - 1)] = GeneW'($urandom());
    a = 0;
    b = 0;
    while (a < plan_n || b < plan_n) begin
      if (b >= plan_n || (a < plan_n && $urandom_range(0, 1) == 1)) begin
        plan_load(1'b0, pool[a]);
        a++;
      end else begin
        plan_load(1'b1, other[b]);
        b++;
      end
    end
    repeat ($urandom_range(1, 3)) plan_random_compute();
  endfunction

  // Random phase: well-formed parent sets with noise (unused funcs, stray
  // loads that may wrap, extra computes once every parent slot is loaded)
  function automatic void plan_random(input int goal);
    int          stop;
    int unsigned r;
    logic [63:0] need;
    stop = planned + goal;
    while (planned < stop) begin
      r    = $urandom_range(0, 99);
      need = (plan_n >= 64) ? '1 : ((64'd1 << plan_n) - 1);
      if (r < 70) begin
        plan_crossover_set();
      end else if (r < 80) begin
        plan_unused();
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) plan_load(1'($urandom()), GeneW'($urandom()));
      end else if (((plan_written_a & plan_written_b) & need) == need) begin
        plan_random_compute();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------
  // Idle means: nothing queued, nothing offered, no child item outstanding.
  // Checked at the falling edge so all edge updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_children.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gene_count(input logic [CountW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    model_gene_count = value;
    plan_n = clamp_count(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued item when the slot is free, unless it leaves a random gap; a stalled
  // item stays untouched. Acceptance feeds the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) crossover_predict(in_item);
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every accepted child item with the oldest prediction,
  // then picks the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_children.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected child item: pos %0d genes %0d/%0d last %0b",
                     out_item.position, out_item.child_one_gene,
                     out_item.child_two_gene, out_item.last_gene);
        end else begin
          want = expected_children.pop_front();
          if (out_item.position !== want.position ||
              out_item.child_one_gene !== want.child_one_gene ||
              out_item.child_two_gene !== want.child_two_gene ||
              out_item.last_gene !== want.last_gene) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("child mismatch: exp pos %0d genes %0d/%0d last %0b,",
                       want.position, want.child_one_gene, want.child_two_gene,
                       want.last_gene,
                       " got pos %0d genes %0d/%0d last %0b",
                       out_item.position, out_item.child_one_gene,
                       out_item.child_two_gene, out_item.last_gene);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    model_gene_count = 7'd64;
    plan_n         = clamp_count(7'd64);
    load_a_count   = 0;
    load_b_count   = 0;
    plan_fill_a    = 0;
    plan_fill_b    = 0;
    plan_written_a = '0;
    plan_written_b = '0;
    planned        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles a third of the time, receiver stalls about half
    set_idling(33, 47);

    // Directed, three genes
    write_gene_count(7'd3);
    plan_load(1'b0, 6'd63);
    plan_load(1'b0, 6'd0);
    plan_load(1'b0, 6'd21);
    plan_load(1'b1, 6'd21);
    plan_load(1'b1, 6'd63);
    plan_load(1'b1, 6'd0);
    plan_unused();                  // func 3 must produce nothing
    plan_compute(6'd1, 7'd3);       // ordinary segment
    plan_compute(6'd2, 7'd0);       // cuts out of order
    plan_compute(6'd1, 7'd1);       // empty segment
    plan_compute(6'd63, 7'd127);    // both cuts beyond the gene count
    plan_compute(6'd0, 7'd64);      // whole permutation
    // parent A overflows and wraps: ends as 9,7,7 (repeated gene)
    plan_load(1'b0, 6'd7);
    plan_load(1'b0, 6'd42);
    plan_load(1'b0, 6'd7);
    plan_load(1'b0, 6'd9);
    plan_load(1'b0, 6'd7);
    plan_load(1'b1, 6'd7);          // parent B becomes 7,63,0
    plan_compute(6'd0, 7'd3);       // some segment slots stay unfilled
    wait_drained();                 // sender holds until every child is out

    write_gene_count(7'd0);         // clamps up to two genes
    plan_random(20);
    wait_drained();

    // roles swapped: sender gaps often, receiver stalls less
    set_idling(47, 33);
    write_gene_count(7'd127);       // clamps down to the full 64 genes
    plan_crossover_set();           // one full parent set of 64 genes
    wait_drained();
    write_gene_count(7'd9);
    plan_random(15);
    wait_drained();

    // full rate both sides
    set_idling(0, 0);
    write_gene_count(7'd1);
    plan_random(15);
    wait_drained();
    write_gene_count(CountW'($urandom_range(2, 20)));
    plan_random(15);
    wait_drained();

    if (mismatch_count == 0 && expected_children.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/pocx_pkg.sv
rtl/permutation_order_crossover_unit.sv
verif/tb_permutation_order_crossover_unit.sv
